FILE: rtl/wear_aware_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef WEAR_AWARE_BLOCK_ALLOCATOR_DEFINES_SVH
`define WEAR_AWARE_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define WABA_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define WABA_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/waba_pkg.sv
// Constants and types of the wear-aware block allocator.
`default_nettype none

package waba_pkg;

   localparam int MAX_BLOCKS        = 1024;
   localparam int META_BLOCKS       = 4;
   localparam int BLOCKS_PER_SECTOR = 2;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = 11;
   localparam int WEAR_W = 16;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [WEAR_W-1:0] WEAR_START = 16'hFFFF;
   localparam logic [CNT_W-1:0]  USED_MAX   = 11'h7FF;
   localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(MAX_BLOCKS);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 3'd0,
      CMD_FREE  = 3'd1,
      CMD_QUERY = 3'd2,
      CMD_NOTE  = 3'd3,
      CMD_LOAD  = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/wear_aware_block_allocator.sv
// Wear-aware flash block allocator: allocation map and wear counts in block RAM.
//
// Channels: req_* carries one request (command in tuser, block index and wear
// value in tdata); rsp_* returns exactly one result per request; csr_* writes
// the partition size register and is always ready (write it only while idle).
// Allocate scans blocks META_BLOCKS .. n-1 (n = min(partition size,
// MAX_BLOCKS)) one RAM entry per cycle over the single read port, then marks
// the least-worn free block. Query reads the map entry; note write increments
// the wear of an even block and of its neighbor if in range; free, load wear
// and rejected requests take effect when the request is accepted.
// Throughput: one request at a time; the next request is taken as soon as the
// previous one has been moved into the result register.
// Reset: a clearing pass over all MAX_BLOCKS (1024) entries writes the map
// (metadata blocks set) and zeroes the wear counts; req_tready stays low during it.
// Stall: a result waits in the output register while rsp_tready is low; one
// more request may be accepted and processed meanwhile, and its result waits
// until the register frees up.
`default_nettype none
`include "wear_aware_block_allocator_defines.svh"

module wear_aware_block_allocator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [31:0]                req_tdata,  // block_index[9:0], wear_value[25:10]
   input  wire logic [waba_pkg::CMD_W-1:0] req_tuser,  // command[2:0]
   // result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [39:0]                     rsp_tdata,  // chosen_block[9:0], chosen_wear[25:10],
                                                       // is_allocated[26], used_total[37:27]
   output logic [waba_pkg::STAT_W-1:0]     rsp_tuser,  // status[1:0]
   // configuration write
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [waba_pkg::CNT_W-1:0] csr_wdata   // partition size
);

   import waba_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_END,
      S_QUERY,
      S_NOTE_FIRST,
      S_NOTE_NEXT,
      S_RESP
   } state_type;

   // Memories and their ports
   logic              map_mem  [MAX_BLOCKS];
   logic [WEAR_W-1:0] wear_mem [MAX_BLOCKS];

   logic              map_we;
   logic [IDX_W-1:0]  map_wa;
   logic              map_wd;
   logic              wear_we;
   logic [IDX_W-1:0]  wear_wa;
   logic [WEAR_W-1:0] wear_wd;
   logic [IDX_W-1:0]  rd_addr;
   logic              map_rd_ff;
   logic [WEAR_W-1:0] wear_rd_ff;

   // Control and result registers
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]  blk_ff, blk_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [WEAR_W-1:0] minw_ff, minw_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  part_size_ff;

   logic [IDX_W-1:0]  res_block_ff, res_block_in;
   logic [WEAR_W-1:0] res_wear_ff, res_wear_in;
   logic              res_isal_ff, res_isal_in;
   status_type        res_status_ff, res_status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [WEAR_W-1:0] rsp_wear_ff, rsp_wear_in;
   logic              rsp_isal_ff, rsp_isal_in;
   logic [CNT_W-1:0]  rsp_used_ff, rsp_used_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Request fields and derived values
   cmd_type           req_command;
   logic [IDX_W-1:0]  req_block;
   logic [WEAR_W-1:0] req_wear;
   logic              req_accept;
   logic [CNT_W-1:0]  n_active;
   logic              in_range;
   logic              scan_hit;
   logic              scan_last;
   logic [CNT_W-1:0]  next_blk;
   logic              rsp_load;

   assign req_command = cmd_type'(req_tuser);
   assign req_block   = req_tdata[IDX_W-1:0];
   assign req_wear    = req_tdata[IDX_W +: WEAR_W];
   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   assign n_active  = (part_size_ff > COUNT_MAX) ? COUNT_MAX : part_size_ff;
   assign in_range  = {1'b0, req_block} < n_active;
   assign scan_hit  = !map_rd_ff && (wear_rd_ff < minw_ff);
   assign scan_last = ({1'b0, scan_idx_ff} == (n_active - CNT_W'(1)));
   assign next_blk  = {1'b0, blk_ff} + CNT_W'(1);
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (wear_we) begin
         wear_mem[wear_wa] <= wear_wd;
      end
      map_rd_ff  <= map_mem[rd_addr];
      wear_rd_ff <= wear_mem[rd_addr];
   end

   // Next-state, memory port and result logic
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      blk_in        = blk_ff;
      scan_idx_in   = scan_idx_ff;
      best_in       = best_ff;
      minw_in       = minw_ff;
      found_in      = found_ff;
      used_in       = used_ff;
      res_block_in  = res_block_ff;
      res_wear_in   = res_wear_ff;
      res_isal_in   = res_isal_ff;
      res_status_in = res_status_ff;
      map_we        = 1'b0;
      map_wa        = blk_ff;
      map_wd        = 1'b0;
      wear_we       = 1'b0;
      wear_wa       = blk_ff;
      wear_wd       = '0;
      rd_addr       = blk_ff;

      unique case (state_ff)
         S_CLEAR: begin
            map_we     = 1'b1;
            map_wa     = clr_idx_ff;
            map_wd     = (clr_idx_ff < IDX_W'(META_BLOCKS));
            wear_we    = 1'b1;
            wear_wa    = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            rd_addr = req_block;
            if (req_accept) begin
               blk_in        = req_block;
               res_block_in  = '0;
               res_wear_in   = '0;
               res_isal_in   = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               case (req_command)
                  CMD_ALLOC: begin
                     rd_addr     = IDX_W'(META_BLOCKS);
                     scan_idx_in = IDX_W'(META_BLOCKS);
                     best_in     = '0;
                     minw_in     = WEAR_START;
                     found_in    = 1'b0;
                     if (n_active <= CNT_W'(META_BLOCKS)) begin
                        res_status_in = ST_NO_FREE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FREE: begin
                     if (!in_range || req_block < IDX_W'(META_BLOCKS)) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        map_we = 1'b1;
                        map_wa = req_block;
                        map_wd = 1'b0;
                        if (used_ff != '0) begin
                           used_in = used_ff - CNT_W'(1);
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (!in_range) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        state_in = S_QUERY;
                     end
                  end
                  CMD_NOTE: begin
                     if (!in_range) begin
                        res_status_in = ST_INVALID;
                     end else if (req_block % BLOCKS_PER_SECTOR == 0) begin
                        state_in = S_NOTE_FIRST;
                     end
                  end
                  CMD_LOAD: begin
                     if (!in_range) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        wear_we = 1'b1;
                        wear_wa = req_block;
                        wear_wd = req_wear;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Compare the entry read last cycle, read the next one
         S_SCAN: begin
            rd_addr     = scan_idx_ff + IDX_W'(1);
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_hit) begin
               best_in  = scan_idx_ff;
               minw_in  = wear_rd_ff;
               found_in = 1'b1;
            end
            if (scan_last) begin
               state_in = S_ALLOC_END;
            end
         end

         S_ALLOC_END: begin
            if (found_ff) begin
               map_we       = 1'b1;
               map_wa       = best_ff;
               map_wd       = 1'b1;
               res_block_in = best_ff;
               res_wear_in  = minw_ff;
               if (used_ff != USED_MAX) begin
                  used_in = used_ff + CNT_W'(1);
               end
            end else begin
               res_status_in = ST_NO_FREE;
            end
            state_in = S_RESP;
         end

         S_QUERY: begin
            res_isal_in = map_rd_ff;
            state_in    = S_RESP;
         end

         // First block of the sector written back, neighbor read
         S_NOTE_FIRST: begin
            wear_we  = 1'b1;
            wear_wa  = blk_ff;
            wear_wd  = wear_rd_ff + WEAR_W'(1);
            rd_addr  = next_blk[IDX_W-1:0];
            state_in = (next_blk < n_active) ? S_NOTE_NEXT : S_RESP;
         end

         S_NOTE_NEXT: begin
            wear_we  = 1'b1;
            wear_wa  = next_blk[IDX_W-1:0];
            wear_wd  = wear_rd_ff + WEAR_W'(1);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_wear_in   = rsp_wear_ff;
      rsp_isal_in   = rsp_isal_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_block_in  = res_block_ff;
         rsp_wear_in   = res_wear_ff;
         rsp_isal_in   = res_isal_ff;
         rsp_used_in   = used_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         used_ff      <= '0;
         found_ff     <= 1'b0;
         part_size_ff <= COUNT_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         used_ff      <= used_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            part_size_ff <= csr_wdata;
         end
      end
      blk_ff        <= blk_in;
      scan_idx_ff   <= scan_idx_in;
      best_ff       <= best_in;
      minw_ff       <= minw_in;
      res_block_ff  <= res_block_in;
      res_wear_ff   <= res_wear_in;
      res_isal_ff   <= res_isal_in;
      res_status_ff <= res_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_wear_ff   <= rsp_wear_in;
      rsp_isal_ff   <= rsp_isal_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_used_ff, rsp_isal_ff, rsp_wear_ff, rsp_block_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Checks
   `WABA_CHECK(a_meta_kept, map_we && (map_wa < IDX_W'(META_BLOCKS)), map_wd,
      "metadata block cleared in allocation map")
   `WABA_CHECK(a_alloc_in_range, (state_ff == S_ALLOC_END) && found_ff,
      (best_ff >= IDX_W'(META_BLOCKS)) && ({1'b0, best_ff} < n_active),
      "allocated block outside the usable range")
   `WABA_CHECK(a_alloc_wear, (state_ff == S_ALLOC_END) && found_ff, minw_ff != WEAR_START,
      "allocated block carries the start wear value")
   `WABA_CHECK_NEXT(a_used_step, 1'b1,
      (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + CNT_W'(1)) ||
      (used_ff == $past(used_ff) - CNT_W'(1)),
      "used count moved by more than one")

endmodule

`default_nettype wire
